FILE: rtl/core/sfdr_pkg.sv
// Shared constants, field widths and codes for the stereo feedback delay reverb.
package sfdr_pkg;

  localparam int unsigned SampleW      = 16;
  localparam int unsigned GainW        = 16;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned LenW         = 13;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam int unsigned LineDepthDef = 4096;
  localparam int unsigned LineWordDef  = 24;

  localparam logic [GainW-1:0] SendReset     = 16'd16384;
  localparam logic [GainW-1:0] FeedbackReset = 16'd55706;
  localparam logic [CoefW-1:0] CosReset      = 16'd29697;
  localparam logic [CoefW-1:0] SinReset      = 16'd13848;
  localparam logic [LenW-1:0]  LeftLenReset  = 13'd1433;
  localparam logic [LenW-1:0]  RightLenReset = 13'd1828;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSend     = 3'd0,
    CfgFeedback = 3'd1,
    CfgCos      = 3'd2,
    CfgSin      = 3'd3,
    CfgLeftLen  = 3'd4,
    CfgRightLen = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StMix   = 2'd1,
    StFeed  = 2'd2,
    StWrite = 2'd3
  } sfdr_state_e;

endpackage

FILE: rtl/core/sfdr_in_if.sv
// Request channel carrying one stereo dry sample pair.
interface sfdr_in_if
  import sfdr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_in;
  logic signed [SampleW-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

FILE: rtl/core/sfdr_out_if.sv
// Result channel carrying one stereo wet/dry sample pair and the clip flag.
interface sfdr_out_if
  import sfdr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_out;
  logic signed [SampleW-1:0] right_out;
  logic                      clipped;

  modport source (output valid, output left_out, output right_out, output clipped,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input clipped,
                  output ready);
endinterface

FILE: rtl/core/stereo_feedback_delay_reverb_core.sv
// Stereo two-line feedback delay reverb with rotation mixing, fixed point.
//
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    left_in, right_in (Q1.15)
//  out_o     out  valid / ready    left_out, right_out (Q1.15), clipped
//  cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// Each request passes through four steps: accept and memory read, cross products,
// mix and feedback products, then saturate, write back and load the output.
// The delay memories need no clearing pass: a per-line fill count marks the
// written prefix, and entries at or above it read as zero.
// A held result stalls the write-back stage; the next request is taken once
// the current one has been written back.
module stereo_feedback_delay_reverb_core
  import sfdr_pkg::*;
#(
  parameter int unsigned LineDepth    = LineDepthDef,
  parameter int unsigned LineWordBits = LineWordDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sfdr_in_if.sink             in_i,
  sfdr_out_if.source          out_o
);

  localparam int unsigned W    = LineWordBits;
  localparam int unsigned AW   = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned FW   = AW + 1;
  localparam int unsigned CW   = (LenW > FW) ? LenW : FW;
  localparam int unsigned PW   = W + CoefW;          // cross product
  localparam int unsigned MW   = W + 2;              // mixed value
  localparam int unsigned FPW  = MW + GainW + 1;     // feedback product
  localparam int unsigned SPW  = SampleW + GainW + 1; // send product
  localparam int unsigned SW   = SPW - GainW;        // scaled input
  localparam int unsigned SUMW = W + 4;              // write sum
  localparam int unsigned OW   = MW + 1;             // output sum

  // Configuration registers
  logic        [GainW-1:0] send_q, feedback_q;
  logic signed [CoefW-1:0] cos_q, sin_q;
  logic        [LenW-1:0]  left_len_q, right_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q      <= SendReset;
      feedback_q  <= FeedbackReset;
      cos_q       <= CosReset;
      sin_q       <= SinReset;
      left_len_q  <= LeftLenReset;
      right_len_q <= RightLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSend:     send_q      <= cfg_data_i[GainW-1:0];
        CfgFeedback: feedback_q  <= cfg_data_i[GainW-1:0];
        CfgCos:      cos_q       <= cfg_data_i[CoefW-1:0];
        CfgSin:      sin_q       <= cfg_data_i[CoefW-1:0];
        CfgLeftLen:  left_len_q  <= cfg_data_i[LenW-1:0];
        CfgRightLen: right_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Control
  sfdr_state_e state_q, state_d;
  logic        accept, commit, out_valid_q;

  always_comb begin
    state_d = state_q;
    commit  = 1'b0;
    case (state_q)
      StIdle:  if (in_i.valid) state_d = StMix;
      StMix:   state_d = StFeed;
      StFeed:  state_d = StWrite;
      StWrite: begin
        if (!out_valid_q || out_o.ready) begin
          commit  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Positions and fill counts: lines are always written as a prefix from entry zero
  logic [AW-1:0] pos_l_q, pos_r_q;
  logic [FW-1:0] fill_l_q, fill_r_q;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                            input logic [LenW-1:0] len);
    logic [CW-1:0] eff;
    logic [CW-1:0] nxt;
    begin
      if (len == '0) begin
        eff = CW'(1);
      end else if (CW'(len) > CW'(LineDepth)) begin
        eff = CW'(LineDepth);
      end else begin
        eff = CW'(len);
      end
      nxt = CW'(pos) + CW'(1);
      advance = (nxt >= eff) ? '0 : nxt[AW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_l_q  <= '0;
      pos_r_q  <= '0;
      fill_l_q <= '0;
      fill_r_q <= '0;
    end else if (commit) begin
      pos_l_q <= advance(pos_l_q, left_len_q);
      pos_r_q <= advance(pos_r_q, right_len_q);
      if (FW'(pos_l_q) >= fill_l_q) fill_l_q <= FW'(pos_l_q) + FW'(1);
      if (FW'(pos_r_q) >= fill_r_q) fill_r_q <= FW'(pos_r_q) + FW'(1);
    end
  end

  // Delay memories
  logic signed [W-1:0] left_mem  [LineDepth];
  logic signed [W-1:0] right_mem [LineDepth];
  logic signed [W-1:0] rd_l_q, rd_r_q;
  logic signed [W-1:0] wr_l, wr_r;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_l_q <= left_mem[pos_l_q];
      rd_r_q <= right_mem[pos_r_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      left_mem[pos_l_q]  <= wr_l;
      right_mem[pos_r_q] <= wr_r;
    end
  end

  // Stage 0: latch dry input, scale by send, mark entries never written
  logic signed [SampleW-1:0] xl_q, xr_q;
  logic signed [SW-1:0]      sl_q, sr_q;
  logic                      vld_l_q, vld_r_q;
  logic signed [SPW-1:0]     send_pl, send_pr;

  assign send_pl = SPW'(in_i.left_in)  * $signed({1'b0, send_q});
  assign send_pr = SPW'(in_i.right_in) * $signed({1'b0, send_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xl_q    <= in_i.left_in;
      xr_q    <= in_i.right_in;
      sl_q    <= send_pl[SPW-1:GainW];
      sr_q    <= send_pr[SPW-1:GainW];
      vld_l_q <= FW'(pos_l_q) < fill_l_q;
      vld_r_q <= FW'(pos_r_q) < fill_r_q;
    end
  end

  // Stage 1: cross products of the line words with the rotation
  logic signed [W-1:0]  l_word, r_word;
  logic signed [PW-1:0] p_lc_q, p_rs_q, p_ls_q, p_rc_q;

  assign l_word = vld_l_q ? rd_l_q : '0;
  assign r_word = vld_r_q ? rd_r_q : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == StMix) begin
      p_lc_q <= PW'(l_word) * PW'(cos_q);
      p_rs_q <= PW'(r_word) * PW'(sin_q);
      p_ls_q <= PW'(l_word) * PW'(sin_q);
      p_rc_q <= PW'(r_word) * PW'(cos_q);
    end
  end

  // Stage 2: mix, drop 15 fraction bits (floor), then feedback products
  logic signed [PW:0]    diff_l, sum_r;
  logic signed [MW-1:0]  lmix, rmix, lmix_q, rmix_q;
  logic signed [FPW-1:0] fb_pl_q, fb_pr_q;

  assign diff_l = (PW+1)'(p_lc_q) - (PW+1)'(p_rs_q);
  assign sum_r  = (PW+1)'(p_ls_q) + (PW+1)'(p_rc_q);
  assign lmix   = diff_l[PW:15];
  assign rmix   = sum_r[PW:15];

  always_ff @(posedge clk_i) begin
    if (state_q == StFeed) begin
      lmix_q  <= lmix;
      rmix_q  <= rmix;
      fb_pl_q <= FPW'(lmix) * $signed({1'b0, feedback_q});
      fb_pr_q <= FPW'(rmix) * $signed({1'b0, feedback_q});
    end
  end

  // Stage 3: saturate line writes and outputs
  logic signed [SUMW-1:0]    wsum_l, wsum_r;
  logic signed [OW-1:0]      osum_l, osum_r;
  logic                      wclip_l, wclip_r, oclip_l, oclip_r;
  logic signed [SampleW-1:0] ol, orr;

  assign wsum_l = SUMW'(sl_q) + SUMW'($signed(fb_pl_q[FPW-1:GainW]));
  assign wsum_r = SUMW'(sr_q) + SUMW'($signed(fb_pr_q[FPW-1:GainW]));
  assign osum_l = OW'(xl_q) + OW'(lmix_q);
  assign osum_r = OW'(xr_q) + OW'(rmix_q);

  assign wclip_l = wsum_l[SUMW-1:W-1] != {(SUMW-W+1){wsum_l[SUMW-1]}};
  assign wclip_r = wsum_r[SUMW-1:W-1] != {(SUMW-W+1){wsum_r[SUMW-1]}};
  assign oclip_l = osum_l[OW-1:SampleW-1] != {(OW-SampleW+1){osum_l[OW-1]}};
  assign oclip_r = osum_r[OW-1:SampleW-1] != {(OW-SampleW+1){osum_r[OW-1]}};

  assign wr_l = !wclip_l ? wsum_l[W-1:0] :
                (wsum_l[SUMW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign wr_r = !wclip_r ? wsum_r[W-1:0] :
                (wsum_r[SUMW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign ol   = !oclip_l ? osum_l[SampleW-1:0] :
                (osum_l[OW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}});
  assign orr  = !oclip_r ? osum_r[SampleW-1:0] :
                (osum_r[OW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}});

  // Output register
  logic signed [SampleW-1:0] out_l_q, out_r_q;
  logic                      clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_l_q <= ol;
      out_r_q <= orr;
      clip_q  <= wclip_l | wclip_r | oclip_l | oclip_r;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;
  assign out_o.clipped   = clip_q;

endmodule
